@@ hdl/gf2bm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gf2bm_pkg;

    // Field widths
    localparam int DEG_W      = 7;
    localparam int LC_W       = 8;
    localparam int GAP_W      = 8;
    localparam int CNT_W      = 8;
    localparam int POLY_OUT_W = 64;

    // Polynomial degree limit, default and legal range
    localparam int MAX_DEGREE_DEF = 64;
    localparam int MAX_DEGREE_MIN = 2;
    localparam int MAX_DEGREE_MAX = 64;

    // Reset values
    localparam logic [DEG_W-1:0] SEQ_DEGREE_RST = DEG_W'(32);
    localparam logic [GAP_W-1:0] GAP_SAT        = {GAP_W{1'b1}};

endpackage

`default_nettype wire

@@ hdl/gf2_linear_complexity_bm.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Binary Berlekamp-Massey engine: takes one sequence bit per cycle unless o_stall holds
// it and, for every bit, returns the running linear complexity and the discrepancy in
// the cycle after the input transfer. A new bit can be taken every cycle that o_stall
// is low. The discrepancy parity, the shifted add of the previous polynomial and the
// packing of the result all sit in the single stage between the state registers and
// the result register. When the bit that completes 2*seq_degree bits arrives, the
// result carries done_res and the connection polynomial (bit j = coefficient of
// degree K-j), and the engine clears itself for the next sequence; restart clears it
// early, before its own bit is used. seq_degree 0 acts as 1. Coefficients above
// MAX_DEGREE are dropped.
module gf2_linear_complexity_bm #(
    parameter int MAX_DEGREE = gf2bm_pkg::MAX_DEGREE_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [gf2bm_pkg::DEG_W-1:0]         i_cfg_data,
    // bit input
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire                                 i_seq_bit,
    input  wire                                 i_restart,
    // result output
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [gf2bm_pkg::LC_W-1:0]          o_linear_complexity,
    output logic                                o_discrepancy,
    output logic                                o_done_res,
    output logic [gf2bm_pkg::POLY_OUT_W-1:0]    o_connection_poly
);

    localparam int PW = MAX_DEGREE + 1;
    localparam int IW = $clog2(PW);
    localparam int LC_W  = gf2bm_pkg::LC_W;
    localparam int GAP_W = gf2bm_pkg::GAP_W;
    localparam int CNT_W = gf2bm_pkg::CNT_W;
    localparam int DEG_W = gf2bm_pkg::DEG_W;
    localparam int OW    = gf2bm_pkg::POLY_OUT_W;

    localparam logic [PW-1:0] POLY_ONE = PW'(1);

    // configuration
    logic [DEG_W-1:0] r_seq_degree;

    // algorithm state
    logic [PW-1:0]    r_conn, n_conn;
    logic [PW-1:0]    r_prev, n_prev;
    logic [PW-1:0]    r_recent, n_recent;
    logic [LC_W-1:0]  r_lc, n_lc;
    logic [GAP_W-1:0] r_gap, n_gap;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // result register
    logic             r_out_valid;
    logic [LC_W-1:0]  r_out_lc, n_out_lc;
    logic             r_out_disc, n_out_disc;
    logic             r_out_done, n_out_done;
    logic [OW-1:0]    r_out_poly, n_out_poly;

    logic             in_xfer;

    // state seen by this bit (after an optional restart)
    logic [PW-1:0]    s_conn, s_prev, s_recent;
    logic [LC_W-1:0]  s_lc;
    logic [GAP_W-1:0] s_gap;
    logic [CNT_W-1:0] s_cnt;

    logic [DEG_W-1:0] k_eff;
    logic [CNT_W:0]   total;
    logic [CNT_W:0]   count;
    logic             disc;
    logic [PW-1:0]    upd_conn, upd_prev;
    logic [LC_W-1:0]  upd_lc;
    logic [GAP_W-1:0] upd_gap;
    logic [GAP_W-1:0] gap_inc;
    logic             done;
    logic [CNT_W-1:0] pack_idx;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_out_valid && i_stall;
    assign in_xfer     = i_valid && !o_stall;

    assign o_valid             = r_out_valid;
    assign o_linear_complexity = r_out_lc;
    assign o_discrepancy       = r_out_disc;
    assign o_done_res          = r_out_done;
    assign o_connection_poly   = r_out_poly;

    always_comb begin
        if (i_restart) begin
            s_conn   = POLY_ONE;
            s_prev   = POLY_ONE;
            s_recent = '0;
            s_lc     = '0;
            s_gap    = GAP_W'(1);
            s_cnt    = '0;
        end else begin
            s_conn   = r_conn;
            s_prev   = r_prev;
            s_recent = r_recent;
            s_lc     = r_lc;
            s_gap    = r_gap;
            s_cnt    = r_cnt;
        end

        k_eff = (r_seq_degree == '0) ? DEG_W'(1) : r_seq_degree;
        total = {(CNT_W - DEG_W)'(0), k_eff, 1'b0};

        n_recent = {s_recent[PW-2:0], i_seq_bit};
        disc     = ^(s_conn & n_recent);
        gap_inc  = (s_gap == gf2bm_pkg::GAP_SAT) ? s_gap : s_gap + GAP_W'(1);

        upd_conn = s_conn;
        upd_prev = s_prev;
        upd_lc   = s_lc;
        upd_gap  = gap_inc;
        if (disc) begin
            // shifts at or past PW give zero, which drops the whole add
            upd_conn = s_conn ^ (s_prev << s_gap);
            if ({1'b0, s_lc, 1'b0} <= {2'b00, s_cnt}) begin
                upd_lc   = s_cnt + LC_W'(1) - s_lc;
                upd_prev = s_conn;
                upd_gap  = GAP_W'(1);
            end
        end

        count = {1'b0, s_cnt} + (CNT_W + 1)'(1);
        done  = (count >= total);

        n_out_lc   = upd_lc;
        n_out_disc = disc;
        n_out_done = done;
        n_out_poly = '0;
        for (int j = 0; j < OW; j++) begin
            pack_idx = CNT_W'(k_eff) - CNT_W'(j);
            if (done && (CNT_W'(j) < CNT_W'(k_eff)) && (pack_idx <= CNT_W'(MAX_DEGREE))) begin
                n_out_poly[j] = upd_conn[pack_idx[IW-1:0]];
            end
        end

        if (done) begin
            n_conn   = POLY_ONE;
            n_prev   = POLY_ONE;
            n_lc     = '0;
            n_gap    = GAP_W'(1);
            n_cnt    = '0;
        end else begin
            n_conn   = upd_conn;
            n_prev   = upd_prev;
            n_lc     = upd_lc;
            n_gap    = upd_gap;
            n_cnt    = count[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_degree <= gf2bm_pkg::SEQ_DEGREE_RST;
            r_conn       <= POLY_ONE;
            r_prev       <= POLY_ONE;
            r_recent     <= '0;
            r_lc         <= '0;
            r_gap        <= GAP_W'(1);
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_seq_degree <= i_cfg_data;
            end
            if (in_xfer) begin
                r_conn      <= n_conn;
                r_prev      <= n_prev;
                r_recent    <= done ? '0 : n_recent;
                r_lc        <= n_lc;
                r_gap       <= n_gap;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_lc   <= n_out_lc;
            r_out_disc <= n_out_disc;
            r_out_done <= n_out_done;
            r_out_poly <= n_out_poly;
        end
    end

endmodule

`default_nettype wire

@@ hdl/gf2bm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gf2bm_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_valid,
    input wire                              o_stall,
    input wire                              o_valid,
    input wire                              i_stall,
    input wire [gf2bm_pkg::LC_W-1:0]        o_linear_complexity,
    input wire                              o_discrepancy,
    input wire                              o_done_res,
    input wire [gf2bm_pkg::POLY_OUT_W-1:0]  o_connection_poly
);

    // an accepted bit always produces a result on the next cycle
    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("input transfer without following result");

    // input only backs up behind a held result
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with result register free");

    // polynomial is only reported on the closing bit
    a_poly_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_connection_poly == '0)
        else $error("connection polynomial reported before done");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_linear_complexity)
            && $stable(o_discrepancy) && $stable(o_done_res)
            && $stable(o_connection_poly))
        else $error("stalled result changed");

endmodule

bind gf2_linear_complexity_bm gf2bm_checker u_gf2bm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_linear_complexity (o_linear_complexity),
    .o_discrepancy       (o_discrepancy),
    .o_done_res          (o_done_res),
    .o_connection_poly   (o_connection_poly)
);

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int POLY_W    = gf2bm_pkg::MAX_DEGREE_DEF + 1;
    localparam int IDLE_MAX  = 4000;
    localparam int DIR_ROWS  = 25;
    localparam int PHASES    = 12;

    typedef struct packed {
        logic [gf2bm_pkg::LC_W-1:0]       lc;
        logic                             disc;
        logic                             done;
        logic [gf2bm_pkg::POLY_OUT_W-1:0] poly;
    } t_bm_res;

    typedef enum logic [1:0] {ROW_TYPED, ROW_PREDICTED, ROW_DEGREE} t_row_kind;

    typedef struct packed {
        t_row_kind                        kind;
        logic [gf2bm_pkg::DEG_W-1:0]      deg;
        logic                             seq_bit;
        logic                             restart;
        logic [gf2bm_pkg::LC_W-1:0]       lc;
        logic                             disc;
        logic                             done;
        logic [gf2bm_pkg::POLY_OUT_W-1:0] poly;
    } t_dir_row;

    typedef enum int {SRC_LFSR, SRC_NOISE, SRC_SPARSE, SRC_BROKEN} t_seq_src;
    typedef enum int {STALL_NONE, STALL_RAND, STALL_PERIOD, STALL_HEAVY} t_stall_mode;

    logic                              i_clk;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [gf2bm_pkg::DEG_W-1:0]       i_cfg_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic                              i_seq_bit = 1'b0;
    logic                              i_restart = 1'b0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic [gf2bm_pkg::LC_W-1:0]        o_linear_complexity;
    logic                              o_discrepancy;
    logic                              o_done_res;
    logic [gf2bm_pkg::POLY_OUT_W-1:0]  o_connection_poly;

    gf2_linear_complexity_bm u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_seq_bit           (i_seq_bit),
        .i_restart           (i_restart),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_linear_complexity (o_linear_complexity),
        .o_discrepancy       (o_discrepancy),
        .o_done_res          (o_done_res),
        .o_connection_poly   (o_connection_poly)
    );

    // Berlekamp-Massey state mirrored on the testbench side
    logic [gf2bm_pkg::DEG_W-1:0]  bm_degree = gf2bm_pkg::SEQ_DEGREE_RST;
    logic [POLY_W-1:0]            bm_conn   = POLY_W'(1);
    logic [POLY_W-1:0]            bm_prev   = POLY_W'(1);
    logic [POLY_W-1:0]            bm_window = '0;
    logic [gf2bm_pkg::LC_W-1:0]   bm_lc     = '0;
    logic [gf2bm_pkg::GAP_W-1:0]  bm_gap    = gf2bm_pkg::GAP_W'(1);
    logic [gf2bm_pkg::CNT_W-1:0]  bm_count  = '0;

    t_bm_res bm_report_q[$];

    int burst_left = 0;
    int n_bits     = 0;
    int n_results  = 0;
    int n_seqs     = 0;
    int n_degrees  = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    // after reset at degree 32, then degree 0/1/127/64/2 corners incl. restart
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{ROW_TYPED,     7'd0,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_TYPED,     7'd0,   1'b1, 1'b0, 8'd2, 1'b1, 1'b0, 64'd0},
        '{ROW_DEGREE,    7'd0,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_TYPED,     7'd0,   1'b1, 1'b0, 8'd1, 1'b1, 1'b0, 64'd0},
        '{ROW_TYPED,     7'd0,   1'b1, 1'b0, 8'd1, 1'b0, 1'b1, 64'd1},
        '{ROW_DEGREE,    7'd1,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_TYPED,     7'd0,   1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_TYPED,     7'd0,   1'b0, 1'b0, 8'd0, 1'b0, 1'b1, 64'd0},
        '{ROW_DEGREE,    7'd127, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_TYPED,     7'd0,   1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_TYPED,     7'd0,   1'b1, 1'b1, 8'd1, 1'b1, 1'b0, 64'd0},
        '{ROW_DEGREE,    7'd64,  1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_DEGREE,    7'd2,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0},
        '{ROW_PREDICTED, 7'd0,   1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 64'd0}
    };

    // -1 picks a random degree for that phase
    int phase_deg   [PHASES] = '{32, 1, 2, 3, 5, 16, 64, 127, 0, -1, -1, -1};
    int phase_items [PHASES] = '{100, 40, 40, 40, 40, 64, 130, 256, 30, 60, 60, 80};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void bm_clear();
        bm_conn   = POLY_W'(1);
        bm_prev   = POLY_W'(1);
        bm_window = '0;
        bm_lc     = '0;
        bm_gap    = gf2bm_pkg::GAP_W'(1);
        bm_count  = '0;
    endfunction

    function automatic t_bm_res bm_absorb_bit(input logic b, input logic rs);
        t_bm_res           r;
        logic [POLY_W-1:0] saved;
        int                k;
        int                n;
        logic              d;
        k = (bm_degree == 0) ? 1 : int'(bm_degree);
        if (rs)
            bm_clear();
        n = bm_count;
        bm_window = {bm_window[POLY_W-2:0], b};
        d = ^(bm_conn & bm_window);
        if (d) begin
            saved = bm_conn;
            // shifts past the top degree contribute nothing
            bm_conn = bm_conn ^ (bm_prev << bm_gap);
            if (2 * bm_lc > n) begin
                if (bm_gap != gf2bm_pkg::GAP_SAT)
                    bm_gap++;
            end else begin
                bm_lc   = 8'(n + 1 - bm_lc);
                bm_prev = saved;
                bm_gap  = gf2bm_pkg::GAP_W'(1);
            end
        end else if (bm_gap != gf2bm_pkg::GAP_SAT) begin
            bm_gap++;
        end
        bm_count = 8'(n + 1);
        r.lc   = bm_lc;
        r.disc = d;
        r.done = (n + 1 >= 2 * k);
        r.poly = '0;
        if (r.done) begin
            for (int j = 0; j < k && j < 64; j++)
                if (k - j < POLY_W)
                    r.poly[j] = bm_conn[k - j];
            bm_clear();
        end
        return r;
    endfunction

    task automatic send_bit(input logic b, input logic rs, input bit typed, input t_bm_res want);
        int      gap;
        t_bm_res exp_res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_seq_bit <= b;
        i_restart <= rs;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        n_bits++;
        exp_res = bm_absorb_bit(b, rs);
        if (typed)
            exp_res = want;
        bm_report_q.insert(bm_report_q.size(), exp_res);
    endtask

    // degree writes only with the engine drained
    task automatic program_degree(input logic [gf2bm_pkg::DEG_W-1:0] v);
        i_valid <= 1'b0;
        burst_left = 0;
        while (bm_report_q.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        bm_degree = v;
        n_degrees++;
    endtask

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:   i_stall <= 1'b0;
            STALL_RAND:   i_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIOD: i_stall <= (stall_left % 3 == 0);
            default:      i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_bm_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (bm_report_q.size() == 0) begin
                $error("result transfer with nothing pending (lc %0d)", o_linear_complexity);
                mismatches++;
            end else begin
                want = bm_report_q.pop_front();
                if (want.done)
                    n_seqs++;
                if (o_linear_complexity !== want.lc) begin
                    $error("linear_complexity: expected %0d, got %0d",
                           want.lc, o_linear_complexity);
                    mismatches++;
                end
                if (o_discrepancy !== want.disc) begin
                    $error("discrepancy: expected %0d, got %0d", want.disc, o_discrepancy);
                    mismatches++;
                end
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, o_done_res);
                    mismatches++;
                end
                if (o_connection_poly !== want.poly) begin
                    $error("connection_poly: expected %h, got %h",
                           want.poly, o_connection_poly);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("timeout: no transfer for %0d cycles", IDLE_MAX);
                $display("gf2_linear_complexity_bm regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row                     row;
        int                           k;
        int                           taps_len;
        int                           seq_len;
        int                           budget;
        int                           deg;
        int                           pick;
        bit                           need_restart;
        bit                           first_seq;
        logic                         b;
        logic                         rs;
        logic [127:0]                 taps;
        logic [127:0]                 hist;
        t_seq_src                     src;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_DEGREE)
                program_degree(row.deg);
            else
                send_bit(row.seq_bit, row.restart, row.kind == ROW_TYPED,
                         '{row.lc, row.disc, row.done, row.poly});
        end

        for (int p = 0; p < PHASES; p++) begin
            if (phase_deg[p] >= 0)
                deg = phase_deg[p];
            else
                deg = (p == PHASES - 1) ? $urandom_range(1, 127) : $urandom_range(1, 12);
            program_degree(gf2bm_pkg::DEG_W'(deg));
            k = (deg == 0) ? 1 : deg;
            budget = phase_items[p];
            need_restart = 1;
            first_seq = 1;
            while (budget > 0) begin
                pick = $urandom_range(0, 9);
                src = (pick <= 6) ? SRC_LFSR : (pick == 7) ? SRC_NOISE :
                      (pick == 8) ? SRC_SPARSE : SRC_BROKEN;
                // long zero runs push the shift gap past the top degree
                if (first_seq && k >= 64)
                    src = SRC_SPARSE;
                first_seq = 0;
                seq_len = (src == SRC_BROKEN) ? $urandom_range(1, 2 * k - 1) : 2 * k;
                taps_len = $urandom_range(1, k);
                taps = {$urandom, $urandom, $urandom, $urandom};
                taps = taps & ((128'd1 << taps_len) - 1);
                taps[taps_len-1] = 1'b1;
                hist = '0;
                for (int i = 0; i < seq_len && budget > 0; i++) begin
                    case (src)
                        SRC_NOISE:  b = 1'($urandom_range(0, 1));
                        SRC_SPARSE: b = ($urandom_range(0, 2 * k) == 0);
                        default:    b = (i < taps_len) ? 1'($urandom_range(0, 1)) : ^(taps & hist);
                    endcase
                    hist = {hist[126:0], b};
                    rs = need_restart || (i == 0 && $urandom_range(0, 7) == 0);
                    need_restart = 0;
                    send_bit(b, rs, 0, '0);
                    budget--;
                end
                if (src == SRC_BROKEN)
                    need_restart = 1;
            end
        end

        i_valid <= 1'b0;
        while (bm_report_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d bit transfers and %0d result transfers under %0d degree writes,",
                 n_bits, n_results, n_degrees);
        $display("%0d sequences completed with a packed polynomial, %0d mismatches",
                 n_seqs, mismatches);
        if (mismatches == 0)
            $display("gf2_linear_complexity_bm regression: pass");
        else
            $display("gf2_linear_complexity_bm regression: fail");
        $finish;
    end

endmodule
